// ----- rtl/pfdc_pkg.sv -----
// ----------------------------------------------------------------------------
// pfdc_pkg: shared types and constants
// Widths, result codes, sequencer states and the result record used by the
// prime factorization block and its submodules.
// ----------------------------------------------------------------------------
package pfdc_pkg;

    localparam int VALUE_WIDTH = 32;
    localparam int IN_WIDTH    = 32;
    localparam int PRIME_WIDTH = 32;
    localparam int EXPO_WIDTH  = 5;
    localparam int COUNT_WIDTH = 11;
    localparam int MAX_OUT     = 9;

    localparam int EXP_W    = $clog2(VALUE_WIDTH + 1);
    localparam int K_W      = $clog2(MAX_OUT + 1);
    localparam int SQ_W     = VALUE_WIDTH + 2;
    localparam int DIV_CNT_W = $clog2(VALUE_WIDTH);
    localparam int TDATA_W  = ((PRIME_WIDTH + EXPO_WIDTH + COUNT_WIDTH + 7) / 8) * 8;

    typedef enum logic [1:0] {
        STATUS_FACTOR = 2'd0,
        STATUS_ONE    = 2'd1,
        STATUS_ZERO   = 2'd2
    } status_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_START,
        ST_SPECIAL,
        ST_TEST,
        ST_DIV,
        ST_RECORD,
        ST_NEXT,
        ST_TAIL,
        ST_FINISH
    } seq_state_t;

    typedef struct packed {
        logic                   done;
        logic                   rem_zero;
    } div_status_t;

    typedef struct packed {
        logic [PRIME_WIDTH-1:0] prime;
        logic [EXPO_WIDTH-1:0]  exponent;
        logic [COUNT_WIDTH-1:0] count;
        logic                   last;
        status_t                status;
    } out_item_t;

endpackage

// ----- rtl/pfdc_div.sv -----
// ----------------------------------------------------------------------------
// pfdc_div: serial restoring divider
// Produces the quotient of dividend / divisor and flags a zero remainder, one
// quotient bit per cycle. Pulses done when the result is up.
// ----------------------------------------------------------------------------
module pfdc_div
    import pfdc_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   start,
    input  logic [VALUE_WIDTH-1:0] dividend,
    input  logic [VALUE_WIDTH-1:0] divisor,
    output logic [VALUE_WIDTH-1:0] quotient,
    output div_status_t            status
);

    logic [VALUE_WIDTH-1:0] r_reg, r_next;
    logic [VALUE_WIDTH-1:0] q_reg, q_next;
    logic [VALUE_WIDTH-1:0] dvs_reg, dvs_next;
    logic [DIV_CNT_W-1:0]   cnt_reg, cnt_next;
    logic                   busy_reg, busy_next;
    logic                   done_reg, done_next;

    logic [VALUE_WIDTH:0]   shifted;
    logic [VALUE_WIDTH+1:0] diff;
    logic                   borrow;

    assign shifted = {r_reg, q_reg[VALUE_WIDTH-1]};
    assign diff    = {1'b0, shifted} - {2'b00, dvs_reg};
    assign borrow  = diff[VALUE_WIDTH+1];

    always_comb begin
        r_next    = r_reg;
        q_next    = q_reg;
        dvs_next  = dvs_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (busy_reg) begin
            r_next   = borrow ? shifted[VALUE_WIDTH-1:0] : diff[VALUE_WIDTH-1:0];
            q_next   = {q_reg[VALUE_WIDTH-2:0], ~borrow};
            cnt_next = cnt_reg - {{(DIV_CNT_W-1){1'b0}}, 1'b1};
            if (cnt_reg == '0) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end else if (start) begin
            r_next    = '0;
            q_next    = dividend;
            dvs_next  = divisor;
            cnt_next  = DIV_CNT_W'(VALUE_WIDTH - 1);
            busy_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        r_reg   <= r_next;
        q_reg   <= q_next;
        dvs_reg <= dvs_next;
    end

    assign quotient        = q_reg;
    assign status.done     = done_reg;
    assign status.rem_zero = (r_reg == '0);

endmodule

// ----- rtl/pfdc_out_stage.sv -----
// ----------------------------------------------------------------------------
// pfdc_out_stage: result output register
// Holds one result record for the master stream and accepts a new one in the
// same cycle the held one is taken.
// ----------------------------------------------------------------------------
module pfdc_out_stage
    import pfdc_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               push_valid,
    input  out_item_t          push_item,
    output logic               push_ready,
    output logic               m_axis_tvalid,
    input  logic               m_axis_tready,
    output logic [TDATA_W-1:0] m_axis_tdata,   // prime_factor, exponent, divisor_count
    output logic               m_axis_tlast,
    output logic [1:0]         m_axis_tuser    // status
);

    logic      valid_reg, valid_next;
    out_item_t item_reg, item_next;

    assign push_ready = !valid_reg || m_axis_tready;

    always_comb begin
        valid_next = valid_reg;
        item_next  = item_reg;
        if (push_valid && push_ready) begin
            valid_next = 1'b1;
            item_next  = push_item;
        end else if (m_axis_tready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        item_reg <= item_next;
    end

    assign m_axis_tvalid = valid_reg;
    assign m_axis_tdata  = TDATA_W'({item_reg.count, item_reg.exponent, item_reg.prime});
    assign m_axis_tlast  = item_reg.last;
    assign m_axis_tuser  = item_reg.status;

endmodule

// ----- rtl/prime_factorization_divisor_count_top.sv -----
// ----------------------------------------------------------------------------
// prime_factorization_divisor_count_top: trial division factorizer
// Factors one number per input transfer and streams one result per distinct
// prime, the last one carrying the divisor count.
// ----------------------------------------------------------------------------
// The block takes one number, accepts nothing more until its last result is
// handed to the output register, and emits the distinct prime factors in
// ascending order with their exponents; tlast marks the final result, which
// also carries the divisor count. Zero and one give a single result. Otherwise
// each trial candidate (2, then odd numbers) is divided in the serial divider,
// and each division that removes a factor is followed by another with the
// same candidate. The serial divider sets the time: a prime input near 2^32
// tries about 32768 candidates; small or smooth numbers finish far sooner.
// ----------------------------------------------------------------------------
module prime_factorization_divisor_count_top
    import pfdc_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_axis_tvalid,
    output logic               s_axis_tready,
    input  logic [IN_WIDTH-1:0] s_axis_tdata,  // number_in
    output logic               m_axis_tvalid,
    input  logic               m_axis_tready,
    output logic [TDATA_W-1:0] m_axis_tdata,   // prime_factor, exponent, divisor_count
    output logic               m_axis_tlast,
    output logic [1:0]         m_axis_tuser    // status
);

    seq_state_t             state_reg, state_next;
    logic [VALUE_WIDTH-1:0] rem_reg, rem_next;
    logic [VALUE_WIDTH-1:0] d_reg, d_next;
    logic [SQ_W-1:0]        sq_reg, sq_next;
    logic [EXP_W-1:0]       e_reg, e_next;
    logic [COUNT_WIDTH-1:0] total_reg, total_next;
    logic [K_W-1:0]         k_reg, k_next;
    logic                   tail_reg, tail_next;
    logic                   pend_reg, pend_next;
    logic [VALUE_WIDTH-1:0] pend_prime_reg, pend_prime_next;
    logic [EXP_W-1:0]       pend_exp_reg, pend_exp_next;

    logic [IN_WIDTH+VALUE_WIDTH-1:0]    in_wide;
    logic [VALUE_WIDTH+PRIME_WIDTH-1:0] prime_wide;
    logic [EXP_W+EXPO_WIDTH-1:0]        exp_wide;
    logic [EXP_W:0]                     e_plus;
    logic [COUNT_WIDTH+EXP_W:0]         prod;
    logic [VALUE_WIDTH-1:0]             src_prime;

    logic                   div_start;
    logic [VALUE_WIDTH-1:0] div_quot;
    div_status_t            div_stat;

    logic                   push_valid;
    logic                   push_ready;
    out_item_t              push_item;

    assign in_wide    = {{VALUE_WIDTH{1'b0}}, s_axis_tdata};
    assign prime_wide = {{PRIME_WIDTH{1'b0}}, pend_prime_reg};
    assign exp_wide   = {{EXPO_WIDTH{1'b0}}, pend_exp_reg};
    assign e_plus     = {1'b0, e_reg} + {{EXP_W{1'b0}}, 1'b1};
    assign prod       = {{(EXP_W+1){1'b0}}, total_reg} * {{COUNT_WIDTH{1'b0}}, e_plus};
    assign src_prime  = tail_reg ? rem_reg : d_reg;

    assign s_axis_tready = (state_reg == ST_IDLE);

    always_comb begin
        state_next      = state_reg;
        rem_next        = rem_reg;
        d_next          = d_reg;
        sq_next         = sq_reg;
        e_next          = e_reg;
        total_next      = total_reg;
        k_next          = k_reg;
        tail_next       = tail_reg;
        pend_next       = pend_reg;
        pend_prime_next = pend_prime_reg;
        pend_exp_next   = pend_exp_reg;
        div_start       = 1'b0;
        push_valid      = 1'b0;
        push_item.prime    = prime_wide[PRIME_WIDTH-1:0];
        push_item.exponent = exp_wide[EXPO_WIDTH-1:0];
        push_item.count    = '0;
        push_item.last     = 1'b0;
        push_item.status   = STATUS_FACTOR;

        case (state_reg)
            ST_IDLE: begin
                if (s_axis_tvalid) begin
                    rem_next   = in_wide[VALUE_WIDTH-1:0];
                    d_next     = VALUE_WIDTH'(2);
                    sq_next    = SQ_W'(4);
                    e_next     = '0;
                    total_next = COUNT_WIDTH'(1);
                    k_next     = '0;
                    tail_next  = 1'b0;
                    pend_next  = 1'b0;
                    state_next = ST_START;
                end
            end
            ST_START: begin
                if (rem_reg <= VALUE_WIDTH'(1)) begin
                    state_next = ST_SPECIAL;
                end else begin
                    state_next = ST_TEST;
                end
            end
            ST_SPECIAL: begin
                push_valid         = 1'b1;
                push_item.prime    = '0;
                push_item.exponent = '0;
                push_item.last     = 1'b1;
                if (rem_reg == '0) begin
                    push_item.count  = '0;
                    push_item.status = STATUS_ZERO;
                end else begin
                    push_item.count  = COUNT_WIDTH'(1);
                    push_item.status = STATUS_ONE;
                end
                if (push_ready) begin
                    state_next = ST_IDLE;
                end
            end
            ST_TEST: begin
                if (sq_reg <= {2'b00, rem_reg}) begin
                    div_start  = 1'b1;
                    state_next = ST_DIV;
                end else begin
                    state_next = ST_TAIL;
                end
            end
            ST_DIV: begin
                if (div_stat.done) begin
                    if (div_stat.rem_zero) begin
                        rem_next  = div_quot;
                        e_next    = e_reg + {{(EXP_W-1){1'b0}}, 1'b1};
                        div_start = 1'b1;
                    end else if (e_reg != '0) begin
                        state_next = ST_RECORD;
                    end else begin
                        state_next = ST_NEXT;
                    end
                end
            end
            ST_RECORD: begin
                if (k_reg < K_W'(MAX_OUT)) begin
                    push_valid = pend_reg;
                    if (!pend_reg || push_ready) begin
                        pend_next       = 1'b1;
                        pend_prime_next = src_prime;
                        pend_exp_next   = e_reg;
                        k_next          = k_reg + {{(K_W-1){1'b0}}, 1'b1};
                        total_next      = prod[COUNT_WIDTH-1:0];
                        e_next          = '0;
                        state_next      = tail_reg ? ST_FINISH : ST_NEXT;
                    end
                end else begin
                    total_next = prod[COUNT_WIDTH-1:0];
                    e_next     = '0;
                    state_next = tail_reg ? ST_FINISH : ST_NEXT;
                end
            end
            ST_NEXT: begin
                if (d_reg == VALUE_WIDTH'(2)) begin
                    d_next  = VALUE_WIDTH'(3);
                    sq_next = SQ_W'(9);
                end else begin
                    d_next  = d_reg + VALUE_WIDTH'(2);
                    sq_next = sq_reg + {d_reg, 2'b00} + SQ_W'(4);
                end
                state_next = ST_TEST;
            end
            ST_TAIL: begin
                if (rem_reg > VALUE_WIDTH'(1)) begin
                    e_next     = EXP_W'(1);
                    tail_next  = 1'b1;
                    state_next = ST_RECORD;
                end else begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH: begin
                push_valid      = 1'b1;
                push_item.count = total_reg;
                push_item.last  = 1'b1;
                if (push_ready) begin
                    pend_next  = 1'b0;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            pend_reg  <= 1'b0;
            tail_reg  <= 1'b0;
            k_reg     <= '0;
        end else begin
            state_reg <= state_next;
            pend_reg  <= pend_next;
            tail_reg  <= tail_next;
            k_reg     <= k_next;
        end
    end

    always_ff @(posedge aclk) begin
        rem_reg        <= rem_next;
        d_reg          <= d_next;
        sq_reg         <= sq_next;
        e_reg          <= e_next;
        total_reg      <= total_next;
        pend_prime_reg <= pend_prime_next;
        pend_exp_reg   <= pend_exp_next;
    end

    pfdc_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (rem_next),
        .divisor  (d_reg),
        .quotient (div_quot),
        .status   (div_stat)
    );

    pfdc_out_stage u_out (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .push_valid    (push_valid),
        .push_item     (push_item),
        .push_ready    (push_ready),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

endmodule
